// ===== src/lla_pkg.sv =====
// Shared constants and types for the life-like automaton line stream core.
package lla_pkg;

  localparam int unsigned MAX_WIDTH  = 1024;
  localparam int unsigned MAX_HEIGHT = 1024;

  localparam int unsigned CFG_DIM_W  = 11;
  localparam int unsigned RULE_W     = 4;
  localparam int unsigned CFG_DATA_W = 11;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned OUT_POS_W  = 10;
  localparam int unsigned ROW_W      = CFG_DIM_W;
  localparam int unsigned COL_W      = $clog2(MAX_WIDTH);
  localparam int unsigned CNT_W      = 4;

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CNT_W = FIFO_PTR_W + 1;

  localparam logic [CFG_DIM_W-1:0] RST_GRID_WIDTH  = CFG_DIM_W'(64);
  localparam logic [CFG_DIM_W-1:0] RST_GRID_HEIGHT = CFG_DIM_W'(64);
  localparam logic [RULE_W-1:0]    RST_BIRTH_MIN   = RULE_W'(3);
  localparam logic [RULE_W-1:0]    RST_BIRTH_MAX   = RULE_W'(3);
  localparam logic [RULE_W-1:0]    RST_SURVIVE_MIN = RULE_W'(2);
  localparam logic [RULE_W-1:0]    RST_SURVIVE_MAX = RULE_W'(3);

  localparam logic MODE_CELL  = 1'b0;
  localparam logic MODE_FLUSH = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRID_WIDTH  = 3'd0,
    REG_GRID_HEIGHT = 3'd1,
    REG_BIRTH_MIN   = 3'd2,
    REG_BIRTH_MAX   = 3'd3,
    REG_SURVIVE_MIN = 3'd4,
    REG_SURVIVE_MAX = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic                 upper;
    logic                 middle;
  } line_pair_t;

  typedef struct packed {
    logic [COL_W-1:0]     col;
    logic                 cur_alive;
    logic                 row_ge1;
    logic                 row_ge2;
    logic                 col_zero;
    logic                 emit;
    logic                 last;
    logic [OUT_POS_W-1:0] out_row;
    logic [OUT_POS_W-1:0] out_col;
  } stage_t;

  typedef struct packed {
    logic                 next_alive;
    logic [OUT_POS_W-1:0] row;
    logic [OUT_POS_W-1:0] col;
    logic                 last;
  } result_t;

endpackage

// ===== src/life_like_automaton_line_stream_core.sv =====
// One generation of a life-like cellular automaton over a raster cell stream.
//
// Input channel (in_valid_i/in_ready_o): one item per transfer, mode_i selects a
// current-generation cell or a flush tick. Cells arrive in raster order; after the
// grid, grid_width+1 flush ticks drain the window.
// Output channel (out_valid_o/out_ready_i): next-generation cell with its row and
// column, last_of_generation_o marks the final cell. Results trail the input by one
// row plus one cell.
// Configuration: cfg_we_i writes cfg_data_i to register cfg_idx_i (grid width,
// grid height, birth min/max, survive min/max); write only while the block is idle.
// A geometry write restarts the generation.
// Throughput: one item per cycle while the result queue has room. The line buffer
// is read at the transfer and the result queued at the next edge.
// The two line buffers share one synchronous memory of MAX_WIDTH two-bit entries,
// read at transfer and written back in the cycle after, with forwarding for width one.
// A four-entry result queue lets input keep flowing while the receiver stalls;
// input stalls only when the queue and the stage in flight fill it.
// Reset restores the register defaults and empties the pipeline; the line buffers
// need no clearing, since rows not yet seen in a generation are masked as dead.
module life_like_automaton_line_stream_core
  import lla_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  mode_i,
  input  logic                  cell_alive_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  next_alive_o,
  output logic [OUT_POS_W-1:0]  out_row_o,
  output logic [OUT_POS_W-1:0]  out_col_o,
  output logic                  last_of_generation_o
);

  localparam logic [CFG_DIM_W-1:0] MaxWDim = CFG_DIM_W'(MAX_WIDTH);
  localparam logic [CFG_DIM_W-1:0] MaxHDim = CFG_DIM_W'(MAX_HEIGHT);

  logic [CFG_DIM_W-1:0] grid_width_q, grid_height_q;
  logic [RULE_W-1:0]    birth_min_q, birth_max_q, survive_min_q, survive_max_q;
  logic                 geom_wr;

  logic [COL_W-1:0]     in_col_q, in_col_d;
  logic [ROW_W-1:0]     in_row_q, in_row_d;
  logic [CFG_DIM_W-1:0] dim_w, dim_h, col_ext, col_inc, pos_c;
  logic [ROW_W-1:0]     pos_r;
  logic                 in_fire;
  stage_t               s0;

  stage_t               s1_q;
  logic                 s1_valid_q;

  line_pair_t           line_mem [MAX_WIDTH];
  line_pair_t           rd_data_q, fwd_data_q, rd_eff, wr_data;
  logic                 fwd_q;

  logic [8:0]           window_q, window_d, win;
  logic [2:0]           triple;
  logic                 top_m, mid_m;
  logic [CNT_W-1:0]     n_live;
  logic                 next_alive;

  result_t              fifo_q [FIFO_DEPTH];
  result_t              push_data, head;
  logic [FIFO_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [FIFO_CNT_W-1:0] cnt_q;
  logic                 push, pop;

  // Configuration registers
  assign geom_wr = cfg_we_i && ((cfg_idx_i == REG_GRID_WIDTH) ||
                                (cfg_idx_i == REG_GRID_HEIGHT));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_width_q  <= RST_GRID_WIDTH;
      grid_height_q <= RST_GRID_HEIGHT;
      birth_min_q   <= RST_BIRTH_MIN;
      birth_max_q   <= RST_BIRTH_MAX;
      survive_min_q <= RST_SURVIVE_MIN;
      survive_max_q <= RST_SURVIVE_MAX;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_GRID_WIDTH:  grid_width_q  <= cfg_data_i;
        REG_GRID_HEIGHT: grid_height_q <= cfg_data_i;
        REG_BIRTH_MIN:   birth_min_q   <= cfg_data_i[RULE_W-1:0];
        REG_BIRTH_MAX:   birth_max_q   <= cfg_data_i[RULE_W-1:0];
        REG_SURVIVE_MIN: survive_min_q <= cfg_data_i[RULE_W-1:0];
        REG_SURVIVE_MAX: survive_max_q <= cfg_data_i[RULE_W-1:0];
        default: ;
      endcase
    end
  end

  // Position tracking and result coordinates at transfer
  assign in_ready_o = (FIFO_CNT_W'(cnt_q) + FIFO_CNT_W'(s1_valid_q)) <
                      FIFO_CNT_W'(FIFO_DEPTH);
  assign in_fire = in_valid_i && in_ready_o;

  always_comb begin
    if (grid_width_q == '0) begin
      dim_w = CFG_DIM_W'(1);
    end else if (grid_width_q > MaxWDim) begin
      dim_w = MaxWDim;
    end else begin
      dim_w = grid_width_q;
    end
    if (grid_height_q == '0) begin
      dim_h = CFG_DIM_W'(1);
    end else if (grid_height_q > MaxHDim) begin
      dim_h = MaxHDim;
    end else begin
      dim_h = grid_height_q;
    end

    col_ext      = CFG_DIM_W'(in_col_q);
    s0.col       = in_col_q;
    s0.cur_alive = (mode_i == MODE_CELL) && (in_row_q < dim_h) && cell_alive_i;
    s0.row_ge1   = in_row_q >= ROW_W'(1);
    s0.row_ge2   = in_row_q >= ROW_W'(2);
    s0.col_zero  = in_col_q == '0;
    if (s0.col_zero) begin
      s0.emit = s0.row_ge2;
      pos_r   = in_row_q - ROW_W'(2);
      pos_c   = dim_w - CFG_DIM_W'(1);
    end else begin
      s0.emit = s0.row_ge1;
      pos_r   = in_row_q - ROW_W'(1);
      pos_c   = col_ext - CFG_DIM_W'(1);
    end
    s0.last    = s0.emit && (pos_r == (dim_h - CFG_DIM_W'(1))) &&
                 (pos_c == (dim_w - CFG_DIM_W'(1)));
    s0.out_row = pos_r[OUT_POS_W-1:0];
    s0.out_col = pos_c[OUT_POS_W-1:0];

    col_inc = col_ext + CFG_DIM_W'(1);
    if (s0.last) begin
      in_col_d = '0;
      in_row_d = '0;
    end else if (col_inc >= dim_w) begin
      in_col_d = '0;
      in_row_d = in_row_q + ROW_W'(1);
    end else begin
      in_col_d = col_inc[COL_W-1:0];
      in_row_d = in_row_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q   <= '0;
      in_row_q   <= '0;
      s1_valid_q <= 1'b0;
      fwd_q      <= 1'b0;
    end else begin
      if (geom_wr) begin
        in_col_q <= '0;
        in_row_q <= '0;
      end else if (in_fire) begin
        in_col_q <= in_col_d;
        in_row_q <= in_row_d;
      end
      s1_valid_q <= in_fire;
      if (in_fire) begin
        fwd_q <= s1_valid_q && (s1_q.col == in_col_q);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_q <= s0;
    end
  end

  // Line buffer memory: read at transfer, write back in the following cycle
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      rd_data_q  <= line_mem[in_col_q];
      fwd_data_q <= wr_data;
    end
    if (s1_valid_q) begin
      line_mem[s1_q.col] <= wr_data;
    end
  end

  assign rd_eff         = fwd_q ? fwd_data_q : rd_data_q;
  assign wr_data.upper  = rd_eff.middle;
  assign wr_data.middle = s1_q.cur_alive;

  // Window update and rule evaluation
  always_comb begin
    top_m  = s1_q.row_ge2 && rd_eff.upper;
    mid_m  = s1_q.row_ge1 && rd_eff.middle;
    triple = {s1_q.cur_alive, mid_m, top_m};
    if (s1_q.col_zero) begin
      win      = {3'b000, window_q[8:3]};
      window_d = {triple, 6'b000000};
    end else begin
      win      = {triple, window_q[8:3]};
      window_d = win;
    end
    if (s1_q.last) begin
      window_d = '0;
    end

    n_live = '0;
    for (int i = 0; i < 9; i++) begin
      if (i != 4) begin
        n_live = n_live + CNT_W'(win[i]);
      end
    end
    if (win[4]) begin
      next_alive = (n_live >= survive_min_q) && (n_live <= survive_max_q);
    end else begin
      next_alive = (n_live >= birth_min_q) && (n_live <= birth_max_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= '0;
    end else if (geom_wr) begin
      window_q <= '0;
    end else if (s1_valid_q) begin
      window_q <= window_d;
    end
  end

  // Result queue
  assign push_data.next_alive = next_alive;
  assign push_data.row        = s1_q.out_row;
  assign push_data.col        = s1_q.out_col;
  assign push_data.last       = s1_q.last;

  assign push = s1_valid_q && s1_q.emit;
  assign pop  = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + FIFO_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + FIFO_PTR_W'(1);
      end
      cnt_q <= cnt_q + FIFO_CNT_W'(push) - FIFO_CNT_W'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= push_data;
    end
  end

  assign head                 = fifo_q[rd_ptr_q];
  assign out_valid_o          = cnt_q != '0;
  assign next_alive_o         = head.next_alive;
  assign out_row_o            = head.row;
  assign out_col_o            = head.col;
  assign last_of_generation_o = head.last;

endmodule
